/* src/mld_pkg.sv */
// ============================================================================
// mld_pkg - shared types and constants for the multipart length deframer
// Keyword text, character codes, queue sizing and the item carried from the
// front end to the output stage.
// ============================================================================
package mld_pkg;

    // Default parameter values for the top level
    localparam int KEYWORD_LEN_DEF = 16;
    localparam int LENGTH_BITS_DEF = 24;

    // Keyword, packed so that byte k counts back from the final character
    localparam int KW_CHARS = 16;
    localparam logic [KW_CHARS*8-1:0] KEYWORD_TEXT = "Content-Length: ";

    // Character codes
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Last index of the three skipped bytes after the carriage return
    localparam logic [1:0] SKIP_LAST = 2'd2;

    // Queue between front end and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* src/mld_front.sv */
// ============================================================================
// mld_front - byte classifier and frame parser
// Hunts for the keyword, reads the decimal length, skips three bytes and
// pushes payload bytes with their last-of-frame mark into the queue.
// ============================================================================
module mld_front #(
    parameter int KEYWORD_LEN = mld_pkg::KEYWORD_LEN_DEF,
    parameter int LENGTH_BITS = mld_pkg::LENGTH_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_in_byte,
    input  mld_pkg::queue_status_t q_stat,
    output logic                  push,
    output mld_pkg::item_t        push_item
);

    localparam int MATCH_N = (KEYWORD_LEN < mld_pkg::KW_CHARS) ? KEYWORD_LEN
                                                               : mld_pkg::KW_CHARS;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_SKIP,
        PH_PAYLOAD
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [7:0]             win_reg   [KEYWORD_LEN];
    logic [7:0]             win_shift [KEYWORD_LEN];
    logic [LENGTH_BITS-1:0] accum_reg, accum_next;
    logic                   done_reg, done_next;
    logic                   seen_reg, seen_next;
    logic [1:0]             skip_reg, skip_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;

    logic                   accept;
    logic                   match;
    logic                   is_digit;
    logic                   is_blank;
    logic                   is_last;
    logic [LENGTH_BITS+3:0] accum_ext;
    logic [LENGTH_BITS+3:0] accum_x10;
    logic [LENGTH_BITS-1:0] accum_sat;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    // Window as it stands after the new byte shifts in
    always_comb begin
        for (int i = 0; i < KEYWORD_LEN - 1; i++) begin
            win_shift[i] = win_reg[i+1];
        end
        win_shift[KEYWORD_LEN-1] = s_in_byte;
    end

    always_comb begin
        match = 1'b1;
        for (int k = 0; k < MATCH_N; k++) begin
            if (win_shift[KEYWORD_LEN-1-k] != mld_pkg::KEYWORD_TEXT[k*8 +: 8]) begin
                match = 1'b0;
            end
        end
    end

    assign is_digit = (s_in_byte >= mld_pkg::CHAR_ZERO) && (s_in_byte <= mld_pkg::CHAR_NINE);
    assign is_blank = (s_in_byte == mld_pkg::CHAR_SPACE) || (s_in_byte == mld_pkg::CHAR_TAB)
                   || (s_in_byte == mld_pkg::CHAR_LF) || (s_in_byte == mld_pkg::CHAR_VT)
                   || (s_in_byte == mld_pkg::CHAR_FF);

    // accum * 10 + digit, saturated
    assign accum_ext = {4'b0000, accum_reg};
    assign accum_x10 = (accum_ext << 3) + (accum_ext << 1)
                     + {{LENGTH_BITS{1'b0}}, s_in_byte[3:0]};
    assign accum_sat = (accum_x10[LENGTH_BITS+3:LENGTH_BITS] != 4'b0000)
                     ? {LENGTH_BITS{1'b1}} : accum_x10[LENGTH_BITS-1:0];

    assign is_last = (left_reg <= {{(LENGTH_BITS-1){1'b0}}, 1'b1});

    always_comb begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        done_next  = done_reg;
        seen_next  = seen_reg;
        skip_next  = skip_reg;
        left_next  = left_reg;
        push       = 1'b0;
        push_item  = '{data: s_in_byte, last: is_last};
        if (accept) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (match) begin
                        phase_next = PH_LENGTH;
                        accum_next = '0;
                        done_next  = 1'b0;
                        seen_next  = 1'b0;
                    end
                end
                PH_LENGTH: begin
                    if (s_in_byte == mld_pkg::CHAR_CR) begin
                        phase_next = PH_SKIP;
                        skip_next  = 2'd0;
                    end else if (!done_reg) begin
                        if (is_digit) begin
                            accum_next = accum_sat;
                            seen_next  = 1'b1;
                        end else if (!seen_reg && is_blank) begin
                            // leading blank: drop
                        end else if (!seen_reg && s_in_byte == mld_pkg::CHAR_PLUS) begin
                            seen_next = 1'b1;
                        end else if (!seen_reg && s_in_byte == mld_pkg::CHAR_MINUS) begin
                            accum_next = '0;
                            done_next  = 1'b1;
                        end else begin
                            done_next = 1'b1;
                        end
                    end
                end
                PH_SKIP: begin
                    if (skip_reg >= mld_pkg::SKIP_LAST) begin
                        skip_next  = 2'd0;
                        left_next  = accum_reg;
                        phase_next = (accum_reg == '0) ? PH_HUNT : PH_PAYLOAD;
                    end else begin
                        skip_next = skip_reg + 2'd1;
                    end
                end
                PH_PAYLOAD: begin
                    push = 1'b1;
                    if (is_last) begin
                        left_next  = '0;
                        phase_next = PH_HUNT;
                    end else begin
                        left_next = left_reg - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            accum_reg <= '0;
            done_reg  <= 1'b0;
            seen_reg  <= 1'b0;
            skip_reg  <= 2'd0;
            left_reg  <= '0;
            for (int i = 0; i < KEYWORD_LEN; i++) begin
                win_reg[i] <= 8'h00;
            end
        end else begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            done_reg  <= done_next;
            seen_reg  <= seen_next;
            skip_reg  <= skip_next;
            left_reg  <= left_next;
            // the window only moves while hunting
            if (accept && phase_reg == PH_HUNT) begin
                for (int i = 0; i < KEYWORD_LEN; i++) begin
                    win_reg[i] <= win_shift[i];
                end
            end
        end
    end

endmodule

/* src/mld_queue.sv */
// ============================================================================
// mld_queue - short item queue
// Decouples the parser from the output stage so each side stalls alone.
// ============================================================================
module mld_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  mld_pkg::item_t         push_item,
    input  logic                   pop,
    output mld_pkg::item_t         pop_item,
    output mld_pkg::queue_status_t status
);

    mld_pkg::item_t             mem_reg [mld_pkg::QUEUE_DEPTH];
    logic [mld_pkg::QUEUE_AW:0] wr_ptr_reg;
    logic [mld_pkg::QUEUE_AW:0] rd_ptr_reg;
    logic                       do_push;
    logic                       do_pop;

    assign status.empty = (wr_ptr_reg == rd_ptr_reg);
    assign status.full  = (wr_ptr_reg[mld_pkg::QUEUE_AW] != rd_ptr_reg[mld_pkg::QUEUE_AW])
        && (wr_ptr_reg[mld_pkg::QUEUE_AW-1:0] == rd_ptr_reg[mld_pkg::QUEUE_AW-1:0]);

    assign do_push  = push && !status.full;
    assign do_pop   = pop && !status.empty;
    assign pop_item = mem_reg[rd_ptr_reg[mld_pkg::QUEUE_AW-1:0]];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg[mld_pkg::QUEUE_AW-1:0]] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + {{mld_pkg::QUEUE_AW{1'b0}}, 1'b1};
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + {{mld_pkg::QUEUE_AW{1'b0}}, 1'b1};
            end
        end
    end

endmodule

/* src/mld_back.sv */
// ============================================================================
// mld_back - output register stage
// Pulls items from the queue into the result register and holds them
// until the downstream side takes the transfer.
// ============================================================================
module mld_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mld_pkg::queue_status_t q_stat,
    output logic                   pop,
    input  mld_pkg::item_t         pop_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_payload_byte,
    output logic                   m_last_of_frame
);

    logic           valid_reg;
    mld_pkg::item_t item_reg;

    // refill whenever the register is empty or being drained this cycle
    assign pop = !q_stat.empty && (!valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= pop_item;
        end
    end

    assign m_valid         = valid_reg;
    assign m_payload_byte  = item_reg.data;
    assign m_last_of_frame = item_reg.last;

endmodule

/* src/multipart_length_deframer.sv */
// ============================================================================
// multipart_length_deframer - frame payload extractor for multipart streams
// Finds "Content-Length: ", reads the decimal length, skips three bytes and
// forwards that many payload bytes, flagging the final one.
// ============================================================================
//
//  Channel  Direction  Ports                               Moves per transfer
//  -------  ---------  ----------------------------------  --------------------------
//  s_       in         s_valid s_ready s_in_byte           one raw stream byte
//  m_       out        m_valid m_ready m_payload_byte      one payload byte + last mark
//                      m_last_of_frame
//
//  Flow: one byte per clock while the queue has room; a payload byte is written
//  into the queue at its input transfer edge and shows on m_ when the output
//  register loads it from the queue.
//  s_ready drops only while the four-entry queue is full, i.e. when m_ready
//  has been held low long enough to back the payload up.
//  Non-payload bytes (hunt, length, skip) never enter the queue.
//  Reset: synchronous, active-low aresetn; clears parse state, the keyword
//  window, the queue pointers and m_valid.
//
module multipart_length_deframer #(
    parameter int KEYWORD_LEN = mld_pkg::KEYWORD_LEN_DEF,
    parameter int LENGTH_BITS = mld_pkg::LENGTH_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic       m_last_of_frame
);

    mld_pkg::queue_status_t q_stat;
    mld_pkg::item_t         push_item;
    mld_pkg::item_t         pop_item;
    logic                   push;
    logic                   pop;

    // Front end: parse every byte, push payload bytes only
    mld_front #(
        .KEYWORD_LEN(KEYWORD_LEN),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_in_byte(s_in_byte),
        .q_stat   (q_stat),
        .push     (push),
        .push_item(push_item)
    );

    // Queue: absorb output stalls without blocking the parser at once
    mld_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_item(push_item),
        .pop      (pop),
        .pop_item (pop_item),
        .status   (q_stat)
    );

    // Back end: registered result channel
    mld_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_stat         (q_stat),
        .pop            (pop),
        .pop_item       (pop_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_last_of_frame(m_last_of_frame)
    );

    // Queue pointers never report full and empty together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    // Output stage pops only from a non-empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    // A push never lands on a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full)
        else $error("push into full queue");

endmodule
